// File: sv/ffha_pkg.sv
// shared types, field widths and codes for the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int SIZE_W = 16;
    localparam int OFF_W  = 13;
    localparam int ST_W   = 2;
    // wide enough for a 16-bit size plus rounding plus header
    localparam int CALC_W = 18;

    localparam int DEF_HEAP_BYTES      = 4096;
    localparam int DEF_HEADER_BYTES    = 8;
    localparam int DEF_MIN_BLOCK_BYTES = 16;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_AREAD,
        S_ACHK,
        S_ASPLIT,
        S_AHDR,
        S_AAFT_RD,
        S_AAFT_WR,
        S_AWHOLE,
        S_LF_RD,
        S_LF_CHK,
        S_FWALK_RD,
        S_FWALK_CHK,
        S_FHDR_CHK,
        S_FNXT_CHK,
        S_FHWR,
        S_FN2_RD,
        S_FN2_WR,
        S_FPRV_RD,
        S_FPRV_CHK,
        S_FNX3_RD,
        S_FNX3_WR,
        S_FIN
    } state_t;

endpackage

// File: sv/ffha_if.sv
// request, response and configuration channels
`timescale 1ns / 1ps
interface ffha_req_if import ffha_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  release_offset;
    modport source (output valid, mode, request_size, release_offset, input ready);
    modport sink   (input valid, mode, request_size, release_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] payload_offset;
    logic [ST_W-1:0]  status;
    modport source (output valid, payload_offset, status, input ready);
    modport sink   (input valid, payload_offset, status, output ready);
endinterface

interface ffha_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/first_fit_heap_allocator_unit.sv
// first-fit heap allocator with boundary-tag headers held in one header memory
//
// channel | dir | payload                                | accepted when
// req     | in  | mode, request_size, release_offset     | req.valid && req.ready
// rsp     | out | payload_offset, status                 | rsp.valid && rsp.ready
// cfg     | in  | data (round_to_four)                   | cfg.valid && cfg.ready
//
// one request at a time; each header visited is a registered memory read followed
// by a check; allocate walks headers from lowest-free and may then walk on to
// update lowest-free, and free walks the headers from offset 0 to the block
// after reset the S_INIT0 and S_INIT1 states write the start and end headers before req.ready rises
// a finished result waits in the output register; the next request is taken meanwhile
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
    parameter int HEAP_BYTES      = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    ffha_req_if.sink      req,
    ffha_rsp_if.source    rsp,
    ffha_cfg_if.sink      cfg
);

    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int EW = 2 * AW + 1;
    localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);

    // header memory: {block length, previous length, in-use}
    logic [EW-1:0] mem [0:HEAP_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;
    logic [EW-1:0] mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_ra];
    end

    logic [AW-1:0] rd_len;
    logic [AW-1:0] rd_prev;
    logic          rd_used;
    assign rd_len  = mem_rd_reg[EW-1:AW+1];
    assign rd_prev = mem_rd_reg[AW:1];
    assign rd_used = mem_rd_reg[0];

    function automatic logic [AW-1:0] next_blk(input logic [AW-1:0] p, input logic [AW-1:0] l);
        logic [AW:0] lim;
        lim = (AW+1)'(HEAP_BYTES) - {1'b0, p};
        if (p >= HEAP_A || l == '0 || {1'b0, l} > lim)
            return HEAP_A;
        return p + l;
    endfunction

    state_t          state_reg, state_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   hdr_reg, hdr_next;
    logic [AW-1:0]   need_reg, need_next;
    logic [AW-1:0]   len_reg, len_next;
    logic [AW-1:0]   prev_reg, prev_next;
    logic [AW-1:0]   nxt_reg, nxt_next;
    logic [AW-1:0]   lf_reg, lf_next;
    logic            merged_reg, merged_next;
    logic            round_reg;
    logic [OFF_W-1:0] roff_reg, roff_next;
    status_t         rst_reg, rst_next;
    logic            ovalid_reg, ovalid_next;
    logic [OFF_W-1:0] ooff_reg, ooff_next;
    status_t         ost_reg, ost_next;

    // request decode
    logic [SIZE_W:0]    size_r;
    logic [CALC_W-1:0]  need_w;
    logic [31:0]        off_w;
    logic [AW-1:0]      rest;
    logic [AW-1:0]      sum_len;
    logic [AW-1:0]      prv_addr;

    always_comb
    begin
        if (round_reg)
            size_r = ((SIZE_W+1)'(req.request_size) + (SIZE_W+1)'(3))
                     & ~(SIZE_W+1)'(3);
        else
            size_r = (SIZE_W+1)'(req.request_size);
        need_w   = CALC_W'(size_r) + CALC_W'(HEADER_BYTES);
        off_w    = 32'(req.release_offset);
        rest     = len_reg - need_reg;
        sum_len  = len_reg + rd_len;
        prv_addr = hdr_reg - prev_reg;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid          = ovalid_reg;
    assign rsp.payload_offset = ooff_reg;
    assign rsp.status         = ost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT0;
            lf_reg     <= '0;
            round_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lf_reg     <= lf_next;
            ovalid_reg <= ovalid_next;
            if (cfg.valid)
            begin
                round_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        hdr_reg    <= hdr_next;
        need_reg   <= need_next;
        len_reg    <= len_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        merged_reg <= merged_next;
        roff_reg   <= roff_next;
        rst_reg    <= rst_next;
        ooff_reg   <= ooff_next;
        ost_reg    <= ost_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        need_next   = need_reg;
        len_next    = len_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        lf_next     = lf_reg;
        merged_next = merged_reg;
        roff_next   = roff_reg;
        rst_next    = rst_reg;
        ooff_next   = ooff_reg;
        ost_next    = ost_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        mem_we      = 1'b0;
        mem_wa      = pos_reg;
        mem_wd      = '0;
        mem_ra      = pos_reg;

        case (state_reg)
            S_INIT0:
            begin
                mem_we     = 1'b1;
                mem_wa     = '0;
                mem_wd     = {HEAP_A, AW'(0), 1'b0};
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                mem_we     = 1'b1;
                mem_wa     = HEAP_A;
                mem_wd     = {AW'(0), HEAP_A, 1'b1};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    roff_next = '0;
                    rst_next  = STAT_DONE;
                    if (req.mode == MODE_ALLOC)
                    begin
                        need_next = AW'(need_w);
                        pos_next  = lf_reg;
                        if (size_r == '0 || need_w > CALC_W'(HEAP_BYTES) || lf_reg >= HEAP_A)
                        begin
                            rst_next   = STAT_NOFIT;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_AREAD;
                        end
                    end
                    else
                    begin
                        hdr_next = AW'(off_w - 32'(HEADER_BYTES));
                        pos_next = '0;
                        if (off_w < 32'(HEADER_BYTES) || off_w >= 32'(HEAP_BYTES))
                        begin
                            rst_next   = STAT_IGNORED;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_FWALK_RD;
                        end
                    end
                end
            end
            // allocate: first-fit walk
            S_AREAD:
            begin
                mem_ra     = pos_reg;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (!rd_used && rd_len >= need_reg)
                begin
                    len_next  = rd_len;
                    prev_next = rd_prev;
                    if (int'(rd_len - need_reg) >= MIN_BLOCK_BYTES)
                        state_next = S_ASPLIT;
                    else
                        state_next = S_AWHOLE;
                end
                else if (next_blk(pos_reg, rd_len) == HEAP_A)
                begin
                    rst_next   = STAT_NOFIT;
                    state_next = S_FIN;
                end
                else
                begin
                    pos_next   = next_blk(pos_reg, rd_len);
                    state_next = S_AREAD;
                end
            end
            S_ASPLIT:
            begin
                mem_we     = 1'b1;
                mem_wa     = pos_reg + need_reg;
                mem_wd     = {rest, need_reg, 1'b0};
                state_next = S_AHDR;
            end
            S_AHDR:
            begin
                mem_we     = 1'b1;
                mem_wa     = pos_reg;
                mem_wd     = {need_reg, prev_reg, 1'b1};
                state_next = S_AAFT_RD;
            end
            S_AAFT_RD:
            begin
                mem_ra     = pos_reg + len_reg;
                state_next = S_AAFT_WR;
            end
            S_AAFT_WR:
            begin
                mem_we    = 1'b1;
                mem_wa    = pos_reg + len_reg;
                mem_wd    = {rd_len, rest, rd_used};
                roff_next = OFF_W'(32'(pos_reg) + 32'(HEADER_BYTES));
                // the split-off remainder is free, so lowest-free lands there
                if (lf_reg == pos_reg)
                    lf_next = pos_reg + need_reg;
                state_next = S_FIN;
            end
            S_AWHOLE:
            begin
                mem_we     = 1'b1;
                mem_wa     = pos_reg;
                mem_wd     = {len_reg, prev_reg, 1'b1};
                roff_next  = OFF_W'(32'(pos_reg) + 32'(HEADER_BYTES));
                state_next = (lf_reg == pos_reg) ? S_LF_RD : S_FIN;
            end
            // advance lowest-free past blocks in use
            S_LF_RD:
            begin
                mem_ra = pos_reg;
                if (pos_reg >= HEAP_A)
                begin
                    lf_next    = HEAP_A;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LF_CHK;
                end
            end
            S_LF_CHK:
            begin
                if (rd_used)
                begin
                    pos_next   = next_blk(pos_reg, rd_len);
                    state_next = S_LF_RD;
                end
                else
                begin
                    lf_next    = pos_reg;
                    state_next = S_FIN;
                end
            end
            // free: confirm the header is a block start from offset 0
            S_FWALK_RD:
            begin
                mem_ra = pos_reg;
                if (pos_reg < hdr_reg)
                    state_next = S_FWALK_CHK;
                else if (pos_reg == hdr_reg)
                    state_next = S_FHDR_CHK;
                else
                begin
                    rst_next   = STAT_IGNORED;
                    state_next = S_FIN;
                end
            end
            S_FWALK_CHK:
            begin
                pos_next   = next_blk(pos_reg, rd_len);
                state_next = S_FWALK_RD;
            end
            S_FHDR_CHK:
            begin
                if (!rd_used)
                begin
                    rst_next   = STAT_IGNORED;
                    state_next = S_FIN;
                end
                else
                begin
                    len_next    = rd_len;
                    prev_next   = rd_prev;
                    merged_next = 1'b0;
                    if (lf_reg > hdr_reg)
                        lf_next = hdr_reg;
                    nxt_next = next_blk(hdr_reg, rd_len);
                    if (next_blk(hdr_reg, rd_len) < HEAP_A)
                    begin
                        mem_ra     = next_blk(hdr_reg, rd_len);
                        state_next = S_FNXT_CHK;
                    end
                    else
                    begin
                        state_next = S_FHWR;
                    end
                end
            end
            S_FNXT_CHK:
            begin
                if (!rd_used)
                begin
                    len_next    = sum_len;
                    nxt_next    = next_blk(hdr_reg, sum_len);
                    merged_next = 1'b1;
                end
                state_next = S_FHWR;
            end
            S_FHWR:
            begin
                mem_we     = 1'b1;
                mem_wa     = hdr_reg;
                mem_wd     = {len_reg, prev_reg, 1'b0};
                state_next = merged_reg ? S_FN2_RD : S_FPRV_RD;
            end
            S_FN2_RD:
            begin
                mem_ra     = nxt_reg;
                state_next = S_FN2_WR;
            end
            S_FN2_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = nxt_reg;
                mem_wd     = {rd_len, len_reg, rd_used};
                state_next = S_FPRV_RD;
            end
            // merge into a free previous neighbor
            S_FPRV_RD:
            begin
                mem_ra = prv_addr;
                if (prev_reg != '0 && prev_reg <= hdr_reg)
                    state_next = S_FPRV_CHK;
                else
                    state_next = S_FIN;
            end
            S_FPRV_CHK:
            begin
                if (!rd_used)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = prv_addr;
                    mem_wd     = {sum_len, rd_prev, 1'b0};
                    len_next   = sum_len;
                    state_next = S_FNX3_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FNX3_RD:
            begin
                mem_ra     = nxt_reg;
                state_next = S_FNX3_WR;
            end
            S_FNX3_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = nxt_reg;
                mem_wd     = {rd_len, len_reg, rd_used};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ooff_next   = (rst_reg == STAT_DONE) ? roff_reg : '0;
                    ost_next    = rst_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ffha_check.sv
// port-level checks for the heap allocator, bound to the top level
`timescale 1ns / 1ps
module ffha_check import ffha_pkg::*; #(
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OFF_W-1:0] out_offset,
    input logic [ST_W-1:0]  out_status
);

    // one transaction in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_offset) && $stable(out_status))
        else $error("response changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != STAT_DONE |-> out_offset == '0)
        else $error("failed transaction carries an offset");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_offset != '0 |->
            32'(out_offset) >= 32'(HEADER_BYTES) && 32'(out_offset) < 32'(HEAP_BYTES))
        else $error("granted offset outside the heap");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status == STAT_DONE || out_status == STAT_NOFIT
                      || out_status == STAT_IGNORED)
        else $error("undefined status code");

endmodule

bind first_fit_heap_allocator_unit ffha_check #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
) u_ffha_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_offset (rsp.payload_offset),
    .out_status (rsp.status)
);
